@@ rtl/sobel_edge_threshold_unit_macros.svh @@
// Assertion macros for the port-level checker of the Sobel edge unit.
`ifndef SOBEL_EDGE_THRESHOLD_UNIT_MACROS_SVH
`define SOBEL_EDGE_THRESHOLD_UNIT_MACROS_SVH

// Check a property at every rising clock edge, reset included.
`define SET_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Check a property only while reset is low.
`define SET_CHECK_LIVE(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

@@ rtl/set_pkg.sv @@
// Shared constants and types for the Sobel edge threshold unit.
`default_nettype none

package set_pkg;

  // Pixel and geometry widths
  localparam int MAX_WIDTH = 1024;
  localparam int PIX_W     = 8;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 16;
  localparam int THR_W     = 11;
  localparam int FW_W      = 11;
  localparam int LIM_W     = 2 * THR_W;
  localparam int SUM_W     = PIX_W + 2;        // t + 2m + b
  localparam int SQ_W      = 2 * SUM_W;
  localparam int WIN       = 3;                // columns in the window

  // Register reset values
  localparam logic [THR_W-1:0] THR_RESET    = THR_W'(128);
  localparam logic [FW_W-1:0]  WIDTH_RESET  = FW_W'(1024);
  localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(1024);

  // One window column: rows r-2, r-1, r
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

  // Position data that travels with a judged pixel
  typedef struct packed {
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } meta_t;

endpackage

`default_nettype wire

@@ rtl/sobel_edge_threshold_unit.sv @@
// Top level of the streaming Sobel 3x3 edge detector with threshold.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------------
//  pixel    | pixel_valid/pixel_stall | pixel_value[7:0]
//  edge     | edge_valid/edge_stall   | edge_flag, centre_row[15:0],
//           |                         | centre_column[9:0], last_interior
//  config   | APB psel/penable/pready | edge_threshold @0, frame_width @4,
//           |                         | frame_height @8
//
// One pixel per cycle is taken while pixel_stall is low; the three column cells
// of the window shift once per pixel. Line stores are read and written once per
// pixel; the upper store is written on its own port. A result passes stages 1 and
// 2 and gradient stages a and b. Reset clears position, window and all stage valid
// bits, not the line stores. An edge stall holds full stages, up to pixel_stall.
`default_nettype none

module sobel_edge_threshold_unit
  import set_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pixel_valid,
  output logic                  pixel_stall,
  input  wire logic [PIX_W-1:0] pixel_value,
  output logic                  edge_valid,
  input  wire logic             edge_stall,
  output logic                  edge_flag,
  output logic      [ROW_W-1:0] centre_row,
  output logic      [COL_W-1:0] centre_column,
  output logic                  last_interior,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [3:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;

  logic [THR_W-1:0] edge_threshold;
  logic [FW_W-1:0]  frame_width;
  logic [ROW_W-1:0] frame_height;
  logic [LIM_W-1:0] lim;
  logic [FW_W-1:0]  act_w;
  logic [ROW_W-1:0] act_h;

  logic [COL_W-1:0] col, col_next;
  logic [ROW_W-1:0] row, row_next;
  logic             accept, col_wrap, row_wrap;

  logic             s1_valid, s1_emit, s1_move;
  logic [PIX_W-1:0] s1_px;
  logic [COL_W-1:0] s1_col;
  meta_t            s1_meta;
  logic             s2_valid, s2_emit, s2_move, s2_free;
  meta_t            s2_meta;
  logic             g_ready;
  logic [PIX_W-1:0] top_rd, mid_rd;

  col_t             win  [WIN];
  col_t             feed [WIN];

  // Configuration writes and reads
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_threshold <= THR_RESET;
      frame_width    <= WIDTH_RESET;
      frame_height   <= HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_THRESHOLD: edge_threshold <= pwdata[THR_W-1:0];
        REG_WIDTH:     frame_width    <= pwdata[FW_W-1:0];
        REG_HEIGHT:    frame_height   <= pwdata[ROW_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'd0) begin
      unique case (paddr[3:2])
        REG_THRESHOLD: prdata = 32'(edge_threshold);
        REG_WIDTH:     prdata = 32'(frame_width);
        REG_HEIGHT:    prdata = 32'(frame_height);
        default:       prdata = '0;
      endcase
    end
  end

  // Squared threshold, refreshed every cycle
  always_ff @(posedge clk) begin
    lim <= LIM_W'(edge_threshold) * LIM_W'(edge_threshold);
  end

  // Clamp frame geometry
  always_comb begin
    if (frame_width < FW_W'(3)) begin
      act_w = FW_W'(3);
    end else if (frame_width > FW_W'(MAX_WIDTH)) begin
      act_w = FW_W'(MAX_WIDTH);
    end else begin
      act_w = frame_width;
    end
    act_h = (frame_height < ROW_W'(3)) ? ROW_W'(3) : frame_height;
  end

  // Handshake through the two front stages
  assign s2_move     = s2_valid && (!s2_emit || g_ready);
  assign s2_free     = !s2_valid || s2_move;
  assign s1_move     = s1_valid && s2_free;
  assign pixel_stall = s1_valid && !s2_free;
  assign accept      = pixel_valid && !pixel_stall;

  // Advance the raster position
  always_comb begin
    col_wrap = ({1'b0, col} + FW_W'(1)) >= act_w;
    row_wrap = ({1'b0, row} + (ROW_W + 1)'(1)) >= {1'b0, act_h};
    col_next = col_wrap ? '0 : col + COL_W'(1);
    row_next = row;
    if (col_wrap) begin
      row_next = row_wrap ? '0 : row + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Stage 1: pixel waits for its line store data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px        <= pixel_value;
      s1_col       <= col;
      s1_emit      <= (row >= ROW_W'(2)) && (col >= COL_W'(2));
      s1_meta.row  <= row - ROW_W'(1);
      s1_meta.col  <= col - COL_W'(1);
      s1_meta.last <= (row == act_h - ROW_W'(1)) && ({1'b0, col} == act_w - FW_W'(1));
    end
  end

  set_line_buffers u_lines (
    .clk        (clk),
    .rd_en      (accept),
    .rd_addr    (col),
    .new_pixel  (pixel_value),
    .up_wr_en   (s1_move),
    .up_wr_addr (s1_col),
    .up_wr_data (mid_rd),
    .top_rd     (top_rd),
    .mid_rd     (mid_rd)
  );

  // Window: newest column enters at the right, each cell hands to the left
  always_comb begin
    feed[WIN-1] = '{top: top_rd, mid: mid_rd, bot: s1_px};
    for (int k = 0; k < WIN - 1; k++) begin
      feed[k] = win[k+1];
    end
  end

  for (genvar k = 0; k < WIN; k++) begin : g_cells
    set_column_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (s1_move),
      .col_in  (feed[k]),
      .col_out (win[k])
    );
  end

  // Stage 2: window holds this pixel's neighborhood; drop border positions
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_move) begin
      s2_valid <= 1'b1;
    end else if (s2_move) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_emit <= s1_emit;
      s2_meta <= s1_meta;
    end
  end

  set_gradient u_grad (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s2_valid && s2_emit),
    .in_ready      (g_ready),
    .in_meta       (s2_meta),
    .win_old       (win[0]),
    .win_mid       (win[1]),
    .win_new       (win[2]),
    .lim           (lim),
    .edge_valid    (edge_valid),
    .edge_stall    (edge_stall),
    .edge_flag     (edge_flag),
    .centre_row    (centre_row),
    .centre_column (centre_column),
    .last_interior (last_interior)
  );

endmodule

`default_nettype wire

@@ rtl/set_line_buffers.sv @@
// Two line stores holding the previous two image rows.
`default_nettype none

module set_line_buffers
  import set_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [COL_W-1:0] rd_addr,
  input  wire logic [PIX_W-1:0] new_pixel,
  input  wire logic             up_wr_en,
  input  wire logic [COL_W-1:0] up_wr_addr,
  input  wire logic [PIX_W-1:0] up_wr_data,
  output logic      [PIX_W-1:0] top_rd,
  output logic      [PIX_W-1:0] mid_rd
);

  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  // Read both rows and store the new pixel into the middle row
  always_ff @(posedge clk) begin
    if (rd_en) begin
      top_rd                <= upper_mem[rd_addr];
      mid_rd                <= middle_mem[rd_addr];
      middle_mem[rd_addr]   <= new_pixel;
    end
  end

  // Move the old middle pixel up one row
  always_ff @(posedge clk) begin
    if (up_wr_en) begin
      upper_mem[up_wr_addr] <= up_wr_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/set_column_cell.sv @@
// One column of the 3x3 window; passes its column to the older neighbor.
`default_nettype none

module set_column_cell
  import set_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic shift,
  input  wire col_t col_in,
  output col_t      col_out
);

  // Load the neighbor column on every window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      col_out <= '0;
    end else if (shift) begin
      col_out <= col_in;
    end
  end

endmodule

`default_nettype wire

@@ rtl/set_gradient.sv @@
// Sobel gradient, squared magnitude and threshold compare, three stages.
`default_nettype none

module set_gradient
  import set_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire meta_t            in_meta,
  input  wire col_t             win_old,
  input  wire col_t             win_mid,
  input  wire col_t             win_new,
  input  wire logic [LIM_W-1:0] lim,
  output logic                  edge_valid,
  input  wire logic             edge_stall,
  output logic                  edge_flag,
  output logic      [ROW_W-1:0] centre_row,
  output logic      [COL_W-1:0] centre_column,
  output logic                  last_interior
);

  logic              a_valid, b_valid;
  logic              a_ready, b_ready, o_ready;
  meta_t             a_meta, b_meta;
  logic [SUM_W-1:0]  a_ax, a_ay;
  logic [SQ_W-1:0]   b_sqx, b_sqy;
  logic [SUM_W-1:0]  sum_r, sum_l, sum_b, sum_t;
  logic [SUM_W:0]    sx, sy;
  logic [SUM_W-1:0]  ax, ay;
  logic [SQ_W:0]     mag;

  // Ready chain from the output register back
  assign o_ready  = !edge_valid || !edge_stall;
  assign b_ready  = !b_valid || o_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  // Kernel sums and absolute gradients
  always_comb begin
    sum_r = SUM_W'(win_new.top) + {1'b0, win_new.mid, 1'b0} + SUM_W'(win_new.bot);
    sum_l = SUM_W'(win_old.top) + {1'b0, win_old.mid, 1'b0} + SUM_W'(win_old.bot);
    sum_b = SUM_W'(win_old.bot) + {1'b0, win_mid.bot, 1'b0} + SUM_W'(win_new.bot);
    sum_t = SUM_W'(win_old.top) + {1'b0, win_mid.top, 1'b0} + SUM_W'(win_new.top);
    sx    = {1'b0, sum_r} - {1'b0, sum_l};
    sy    = {1'b0, sum_b} - {1'b0, sum_t};
    ax    = sx[SUM_W] ? SUM_W'(-sx) : sx[SUM_W-1:0];
    ay    = sy[SUM_W] ? SUM_W'(-sy) : sy[SUM_W-1:0];
  end

  assign mag = {1'b0, b_sqx} + {1'b0, b_sqy};

  // Control of the three stages
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      edge_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= in_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (o_ready) begin
        edge_valid <= b_valid;
      end
    end
  end

  // Payload of the three stages
  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_meta <= in_meta;
      a_ax   <= ax;
      a_ay   <= ay;
    end
    if (b_ready && a_valid) begin
      b_meta <= a_meta;
      b_sqx  <= SQ_W'(a_ax) * SQ_W'(a_ax);
      b_sqy  <= SQ_W'(a_ay) * SQ_W'(a_ay);
    end
    if (o_ready && b_valid) begin
      edge_flag     <= ({1'b0, mag} > (SQ_W + 2)'(lim));
      centre_row    <= b_meta.row;
      centre_column <= b_meta.col;
      last_interior <= b_meta.last;
    end
  end

endmodule

`default_nettype wire

@@ rtl/set_checker.sv @@
// Port-level checks for the Sobel edge threshold unit, bound to the top level.
`default_nettype none

`include "sobel_edge_threshold_unit_macros.svh"

module set_checker
  import set_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             pixel_stall,
  input wire logic             edge_valid,
  input wire logic             edge_stall,
  input wire logic [ROW_W-1:0] centre_row,
  input wire logic [COL_W-1:0] centre_column
);

  // No result is offered right after reset
  `SET_CHECK(a_reset_quiet, rst |=> !edge_valid, "edge_valid high after reset")

  // A free output side never holds the pixel side
  `SET_CHECK_LIVE(a_no_stall_when_free, !edge_stall |-> !pixel_stall, "pixel stalled while edge side free")

  // Judged pixels are interior, never on the first row or column
  `SET_CHECK_LIVE(a_interior_only, edge_valid |-> (centre_row != '0) && (centre_column != '0), "border pixel reported")

  // A stalled result stays offered
  `SET_CHECK_LIVE(a_hold_valid, edge_valid && edge_stall |=> edge_valid, "result dropped while stalled")

endmodule

bind sobel_edge_threshold_unit set_checker u_checker (.*);

`default_nettype wire

@@ dv/sobel_tb_pkg.sv @@
// Register map shared by the Sobel edge testbench top and its checker.
package sobel_tb_pkg;

  // Byte addresses of the configuration registers
  typedef enum logic [3:0] {
    REG_THRESHOLD = 4'h0,
    REG_WIDTH     = 4'h4,
    REG_HEIGHT    = 4'h8
  } reg_addr_e;

endpackage

@@ dv/sobel_edge_checker.sv @@
// Checker for the Sobel edge unit: tracks registers, predicts edge results, compares.
module sobel_edge_checker
  import set_pkg::*;
  import sobel_tb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             pixel_valid,
  input  logic             pixel_stall,
  input  logic [PIX_W-1:0] pixel_value,
  input  logic             edge_valid,
  input  logic             edge_stall,
  input  logic             edge_flag,
  input  logic [ROW_W-1:0] centre_row,
  input  logic [COL_W-1:0] centre_column,
  input  logic             last_interior,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  input  logic [31:0]      prdata,
  input  logic             pready,
  output int               failures,
  output int               pending,
  output int               results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             flag;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } edge_result_t;

  // Own copy of line stores, window, position and registers
  logic [PIX_W-1:0] upper_row  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_row [MAX_WIDTH];
  col_t             window     [WIN];
  int               col_pos;
  int               row_pos;
  logic [THR_W-1:0] threshold;
  logic [FW_W-1:0]  frame_width;
  logic [ROW_W-1:0] frame_height;
  edge_result_t     expected_edges [$];

  initial begin
    foreach (upper_row[i]) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
  end

  task automatic report_mismatch(input string msg);
    failures = failures + 1;
    $display("%0t ns checker: %s", $time, msg);
  endtask

  // Shift one pixel through line stores and window; queue a result for interior centres
  task automatic judge_pixel(input logic [PIX_W-1:0] px);
    int           w_act;
    int           h_act;
    int           gx;
    int           gy;
    int           mag;
    int           lim;
    col_t         fresh;
    edge_result_t res;
    w_act = (frame_width < 3) ? 3 :
            (frame_width > MAX_WIDTH) ? MAX_WIDTH : int'(frame_width);
    h_act = (frame_height < 3) ? 3 : int'(frame_height);
    fresh.top = upper_row[col_pos];
    fresh.mid = middle_row[col_pos];
    fresh.bot = px;
    upper_row[col_pos]  = middle_row[col_pos];
    middle_row[col_pos] = px;
    window[0] = window[1];
    window[1] = window[2];
    window[2] = fresh;
    if (row_pos >= 2 && col_pos >= 2) begin
      // right column minus left column, bottom row minus top row
      gx = (int'(window[2].top) + 2 * int'(window[2].mid) + int'(window[2].bot))
         - (int'(window[0].top) + 2 * int'(window[0].mid) + int'(window[0].bot));
      gy = (int'(window[0].bot) + 2 * int'(window[1].bot) + int'(window[2].bot))
         - (int'(window[0].top) + 2 * int'(window[1].top) + int'(window[2].top));
      mag = gx * gx + gy * gy;
      lim = int'(threshold) * int'(threshold);
      res.flag = (mag > lim);
      res.row  = ROW_W'(row_pos - 1);
      res.col  = COL_W'(col_pos - 1);
      res.last = (row_pos == h_act - 1) && (col_pos == w_act - 1);
      expected_edges.push_back(res);
    end
    // advance position, wrapping at end of row and frame
    if (col_pos + 1 >= w_act) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h_act) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  function automatic logic [31:0] reg_value(input logic [3:0] addr);
    case (reg_addr_e'(addr))
      REG_THRESHOLD: return 32'(threshold);
      REG_WIDTH:     return 32'(frame_width);
      REG_HEIGHT:    return 32'(frame_height);
      default:       return '0;
    endcase
  endfunction

  always @(posedge clk) begin
    edge_result_t want;
    if (rst) begin
      foreach (window[i]) window[i] = '0;
      col_pos      = 0;
      row_pos      = 0;
      threshold    = THR_RESET;
      frame_width  = WIDTH_RESET;
      frame_height = HEIGHT_RESET;
      failures     = 0;
      results_seen = 0;
      expected_edges.delete();
    end else begin
      // track register writes, check reads
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_addr_e'(paddr))
            REG_THRESHOLD: threshold    = pwdata[THR_W-1:0];
            REG_WIDTH:     frame_width  = pwdata[FW_W-1:0];
            REG_HEIGHT:    frame_height = pwdata[ROW_W-1:0];
            default:       ;
          endcase
        end else if (prdata !== reg_value(paddr)) begin
          report_mismatch($sformatf("prdata at 0x%0h: got %0d, expected %0d",
                                    paddr, prdata, reg_value(paddr)));
        end
      end
      // predict on each pixel transfer
      if (pixel_valid && !pixel_stall) judge_pixel(pixel_value);
      // compare each edge transfer with the oldest prediction
      if (edge_valid && !edge_stall) begin
        if (expected_edges.size() == 0) begin
          report_mismatch($sformatf("edge result (%0d,%0d) with none expected",
                                    centre_row, centre_column));
        end else begin
          want = expected_edges.pop_front();
          results_seen = results_seen + 1;
          if (edge_flag !== want.flag)
            report_mismatch($sformatf("edge_flag at (%0d,%0d): got %b, expected %b",
                                      want.row, want.col, edge_flag, want.flag));
          if (centre_row !== want.row)
            report_mismatch($sformatf("centre_row: got %0d, expected %0d",
                                      centre_row, want.row));
          if (centre_column !== want.col)
            report_mismatch($sformatf("centre_column: got %0d, expected %0d",
                                      centre_column, want.col));
          if (last_interior !== want.last)
            report_mismatch($sformatf("last_interior at (%0d,%0d): got %b, expected %b",
                                      want.row, want.col, last_interior, want.last));
        end
      end
    end
    pending <= expected_edges.size();
  end

endmodule

@@ dv/tb.sv @@
// Testbench top for the Sobel edge unit: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import set_pkg::*;
  import sobel_tb_pkg::*;

  localparam int ITEMS        = 1250;
  localparam int DRAIN_CYCLES = 8;
  localparam int THR_MAX      = 2047;
  localparam int HEIGHT_MAX   = 65535;

  typedef enum int {PIX_NOISE, PIX_BINARY, PIX_SMOOTH, PIX_BARS, PIX_STEP} pixel_style_e;

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             pixel_valid = 1'b0;
  logic [PIX_W-1:0] pixel_value = '0;
  logic             edge_stall  = 1'b0;
  logic             psel        = 1'b0;
  logic             penable     = 1'b0;
  logic             pwrite      = 1'b0;
  logic [3:0]       paddr       = '0;
  logic [31:0]      pwdata      = '0;
  logic             pixel_stall;
  logic             edge_valid;
  logic             edge_flag;
  logic [ROW_W-1:0] centre_row;
  logic [COL_W-1:0] centre_column;
  logic             last_interior;
  logic [31:0]      prdata;
  logic             pready;
  int               failures;
  int               pending;
  int               results_seen;

  int               sent          = 0;
  int               setups        = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  logic [PIX_W-1:0] last_pixel    = '0;

  sobel_edge_threshold_unit dut (.*);

  sobel_edge_checker edge_check (.*);

  initial forever #4 clk = ~clk;

  // Random stall on the result channel
  always @(posedge clk) begin
    if (rst) begin
      edge_stall <= 1'b0;
    end else begin
      edge_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // One APB transfer: setup cycle, then access until pready
  task automatic apb_access(input reg_addr_e addr, input int data, input bit is_write);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= 32'(data);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Send one pixel after a random gap; return once it is transferred
  task automatic send_pixel(input logic [PIX_W-1:0] v);
    if (sent < ITEMS / 3) begin
      send_idle_pct = 34;
      recv_idle_pct <= 45;
    end else if (sent < 2 * ITEMS / 3) begin
      send_idle_pct = 45;
      recv_idle_pct <= 34;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct <= 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_value <= v;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    sent++;
  endtask

  // Hold the sender until every predicted result has come out
  task automatic wait_idle();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] make_pixel(input pixel_style_e style,
                                                   input int r, input int c);
    int v;
    case (style)
      PIX_NOISE:  v = $urandom_range(255);
      PIX_BINARY: v = $urandom_range(1) ? 255 : 0;
      PIX_SMOOTH: begin
        v = int'(last_pixel) + int'($urandom_range(40)) - 20;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      PIX_BARS:   v = ((((c / 2) + r) % 2) != 0 ? 210 : 30) + int'($urandom_range(15));
      default:    v = (c >= 2) ? 255 : 0;
    endcase
    last_pixel = v[PIX_W-1:0];
    return v[PIX_W-1:0];
  endfunction

  task automatic feed_pixels(input pixel_style_e style, input int w, input int count);
    int i;
    for (i = 0; i < count; i++) send_pixel(make_pixel(style, i / w, i % w));
  endtask

  function automatic int pick_threshold();
    case ($urandom_range(9))
      0:       return 0;
      1:       return THR_MAX;
      2:       return $urandom_range(60);
      default: return $urandom_range(1450);
    endcase
  endfunction

  // Drain, write all registers, read one back
  task automatic setup_frame(input int thr, input int w_reg, input int h_reg);
    wait_idle();
    apb_access(REG_THRESHOLD, thr, 1'b1);
    apb_access(REG_WIDTH, w_reg, 1'b1);
    apb_access(REG_HEIGHT, h_reg, 1'b1);
    case ($urandom_range(2))
      0:       apb_access(REG_THRESHOLD, 0, 1'b0);
      1:       apb_access(REG_WIDTH, 0, 1'b0);
      default: apb_access(REG_HEIGHT, 0, 1'b0);
    endcase
    setups++;
  endtask

  initial begin
    pixel_style_e style;
    int           seg;
    int           w_eff;
    int           h_eff;
    int           w_reg;
    int           h_reg;
    seg      = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: vertical step of full height, magnitude exactly 1020; the
    // frame sizes are written at or below the minimum and act as 3x3
    setup_frame(1020, 0, 1);
    feed_pixels(PIX_STEP, 3, 9);
    setup_frame(1019, 2, 2);
    feed_pixels(PIX_STEP, 3, 9);
    setup_frame(THR_MAX, 3, 0);
    feed_pixels(PIX_STEP, 3, 9);

    // Random frames, with resizing mid-frame
    while (sent < ITEMS) begin
      style = pixel_style_e'($urandom_range(3));
      if (seg % 12 == 0) begin
        // narrow the width in mid-row; the position wraps at the next pixel
        setup_frame(pick_threshold(), 10, 6);
        feed_pixels(style, 10, 38);
        setup_frame(pick_threshold(), 4, 6);
        feed_pixels(style, 4, 9);
      end else if (seg % 12 == 6) begin
        // tallest frame, then cut the height so the row wraps to zero
        setup_frame(pick_threshold(), 3, HEIGHT_MAX);
        feed_pixels(style, 3, 30);
        setup_frame(pick_threshold(), 3, 3);
        feed_pixels(style, 3, 3);
      end else begin
        w_eff = ($urandom_range(9) == 0) ? 3 : $urandom_range(14, 3);
        h_eff = $urandom_range(9, 3);
        w_reg = (w_eff == 3 && $urandom_range(1) == 1) ? $urandom_range(2) : w_eff;
        h_reg = (h_eff == 3 && $urandom_range(1) == 1) ? $urandom_range(2) : h_eff;
        setup_frame(pick_threshold(), w_reg, h_reg);
        feed_pixels(style, w_eff, w_eff * h_eff);
      end
      seg++;
    end

    wait_idle();
    $display("Run covered %0d pixel transfers and %0d checked edge results over %0d setups,",
             sent, results_seen, setups);
    $display("including clamped sizes and mid-frame resizing of width and height.");
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #5ms;
    $display("Timeout: stimulus or results did not complete");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/set_pkg.sv
rtl/set_line_buffers.sv
rtl/set_column_cell.sv
rtl/set_gradient.sv
rtl/sobel_edge_threshold_unit.sv
rtl/set_checker.sv
dv/sobel_tb_pkg.sv
dv/sobel_edge_checker.sv
dv/tb.sv
